FILE: src/sqrg_pkg.sv
// sqrg_pkg: shared types, operation codes and constants of the session quota
// and rate governor. Depends on nothing.
package sqrg_pkg;

    localparam int CNT_W   = 48;                  // byte counters and limits
    localparam int RATE_W  = 32;                  // output rate register
    localparam int FRAC_W  = 30;                  // token fraction bits
    localparam int TOK_W   = RATE_W + FRAC_W;     // token level width
    localparam int PROD_W  = TOK_W + RATE_W;      // product and dividend register
    localparam int NS_W    = 30;                  // bits of one second in ns
    localparam int DIV_W   = TOK_W + NS_W;        // dividend bits fed to the divider
    localparam int STEP_W  = 7;                   // serial step counter

    localparam logic [STEP_W-1:0] MUL_LAST = STEP_W'(TOK_W - 1);
    localparam logic [STEP_W-1:0] DIV_LAST = STEP_W'(DIV_W - 1);

    localparam logic [RATE_W-1:0] NS_PER_SEC = RATE_W'(1000000000);

    localparam logic [CNT_W-1:0]  MEM_LIMIT_RST = CNT_W'(1073741824);
    localparam logic [CNT_W-1:0]  IMG_LIMIT_RST = CNT_W'(67108864);
    localparam logic [RATE_W-1:0] RATE_RST      = RATE_W'(1048576);

    // operation codes
    localparam logic [2:0] OP_RES_MEM = 3'd0;
    localparam logic [2:0] OP_REL_MEM = 3'd1;
    localparam logic [2:0] OP_RES_IMG = 3'd2;
    localparam logic [2:0] OP_REC_IMG = 3'd3;
    localparam logic [2:0] OP_DELAY   = 3'd4;
    localparam logic [2:0] OP_CONSUME = 3'd5;

    // register indexes
    localparam logic [1:0] CFG_MEM_LIMIT = 2'd0;
    localparam logic [1:0] CFG_IMG_LIMIT = 2'd1;
    localparam logic [1:0] CFG_RATE      = 2'd2;

    // sticky reason codes
    localparam logic [1:0] REASON_NONE = 2'd0;
    localparam logic [1:0] REASON_MEM  = 2'd1;
    localparam logic [1:0] REASON_IMG  = 2'd2;
    localparam logic [1:0] REASON_OUT  = 2'd3;

    typedef enum logic [2:0] {
        ST_IDLE,
        ST_EXEC,
        ST_MUL,
        ST_DIV,
        ST_ADD,
        ST_CHK,
        ST_ROUND,
        ST_FIN
    } t_state;

endpackage

FILE: src/session_quota_and_rate_governor_unit.sv
// session_quota_and_rate_governor_unit: quota counters, output token bucket
// and sticky limit reason with a bit-serial multiplier and divider; uses sqrg_pkg.
// order: accepted word, execute state, then finish state; a delay query may add a refill
// pass and a wait pass, each of 62 multiply steps then 92 divide steps
// throughput: one word at a time, the next taken the cycle after the result is
// registered; a held result stalls. sync active-low reset: defaults, full bucket
module session_quota_and_rate_governor_unit (
    input  logic                         i_clk,
    input  logic                         i_rst_n,
    input  logic                         i_cfg_valid,
    output logic                         o_cfg_ready,
    input  logic [1:0]                   i_cfg_index,
    input  logic [sqrg_pkg::CNT_W-1:0]   i_cfg_data,
    input  logic                         i_in_valid,
    output logic                         o_in_ready,
    input  logic [2:0]                   i_op,
    input  logic [sqrg_pkg::CNT_W-1:0]   i_amount,
    input  logic [62:0]                  i_now_ns,
    output logic                         o_out_valid,
    input  logic                         i_out_ready,
    output logic                         o_granted,
    output logic [sqrg_pkg::NS_W-1:0]    o_delay_ns,
    output logic [1:0]                   o_first_hit,
    output logic [sqrg_pkg::CNT_W-1:0]   o_memory_in_use,
    output logic [sqrg_pkg::CNT_W-1:0]   o_image_in_use
);
    import sqrg_pkg::*;

    t_state r_state, n_state;

    logic [CNT_W-1:0]  r_mem_lim, r_img_lim;
    logic [RATE_W-1:0] r_rate;
    logic [CNT_W-1:0]  r_mem_cnt, r_img_cnt;
    logic [TOK_W-1:0]  r_level;
    logic [62:0]       r_last;
    logic [1:0]        r_sticky;

    logic [2:0]        r_op;
    logic [CNT_W-1:0]  r_amt;
    logic [62:0]       r_now;

    logic [PROD_W-1:0] r_acc;
    logic [RATE_W-1:0] r_rem;
    logic [TOK_W-1:0]  r_quo;
    logic [STEP_W-1:0] r_cnt;
    logic              r_phase;   // 0 refill, 1 wait computation
    logic              r_granted;
    logic [NS_W-1:0]   r_delay;

    logic              r_out_valid;
    logic              r_o_granted;
    logic [NS_W-1:0]   r_o_delay;
    logic [1:0]        r_o_reason;
    logic [CNT_W-1:0]  r_o_mem, r_o_img;

    // combinational datapath
    logic [TOK_W-1:0]  w_cap;
    logic [CNT_W:0]    w_mem_room, w_img_room;
    logic              w_mem_refuse, w_img_refuse;
    logic [63:0]       w_diff;
    logic              w_oversize, w_refill, w_full;
    logic [RATE_W-1:0] w_mul_a, w_div_d;
    logic [RATE_W:0]   w_mul_t;
    logic [PROD_W-1:0] w_mul_next;
    logic [RATE_W:0]   w_rem_sh, w_rem_n;
    logic              w_ge;
    logic [TOK_W:0]    w_sum;
    logic [TOK_W-1:0]  w_wanted;
    logic [63:0]       w_consume_w;
    logic [TOK_W-1:0]  w_qc;
    logic              w_out_free;
    logic              w_grant;

    always_comb begin
        w_cap        = {r_rate, FRAC_W'(0)};
        w_mem_room   = {1'b0, r_mem_lim} - {1'b0, r_amt};
        w_img_room   = {1'b0, r_img_lim} - {1'b0, r_amt};
        w_mem_refuse = w_mem_room[CNT_W] || (r_mem_cnt > w_mem_room[CNT_W-1:0]);
        w_img_refuse = w_img_room[CNT_W] || (r_img_cnt > w_img_room[CNT_W-1:0]);

        w_diff     = {1'b0, r_now} - {1'b0, r_last};
        w_oversize = r_amt > {{(CNT_W-RATE_W){1'b0}}, r_rate};
        w_refill   = !w_diff[63] && (w_diff != 64'd0);
        w_full     = w_diff[62:0] >= {33'd0, NS_PER_SEC[NS_W-1:0]};

        // shift-add step: multiplier bits sit in the low end of the register
        w_mul_a    = r_phase ? NS_PER_SEC : r_rate;
        w_mul_t    = {1'b0, r_acc[PROD_W-1:TOK_W]} + (r_acc[0] ? {1'b0, w_mul_a} : '0);
        w_mul_next = {w_mul_t, r_acc[TOK_W-1:1]};

        // restoring division step, dividend fed msb first
        w_div_d  = r_phase ? r_rate : NS_PER_SEC;
        w_rem_sh = {r_rem, r_acc[PROD_W-1]};
        w_ge     = w_rem_sh >= {1'b0, w_div_d};
        w_rem_n  = w_ge ? (w_rem_sh - {1'b0, w_div_d}) : w_rem_sh;

        w_sum       = {1'b0, r_level} + {1'b0, r_quo};
        w_wanted    = {r_amt[RATE_W-1:0], FRAC_W'(0)};
        w_consume_w = {r_amt[63-FRAC_W:0], FRAC_W'(0)};
        w_qc        = r_quo + {{(TOK_W-1){1'b0}}, (r_rem != '0)};
        w_out_free  = !r_out_valid || i_out_ready;

        case (r_op)
            OP_RES_MEM: w_grant = !w_mem_refuse;
            OP_REL_MEM: w_grant = 1'b1;
            OP_RES_IMG: w_grant = !w_img_refuse;
            OP_REC_IMG: w_grant = (r_amt <= r_img_lim);
            OP_DELAY:   w_grant = !w_oversize;
            OP_CONSUME: w_grant = 1'b1;
            default:    w_grant = 1'b0;
        endcase
    end

    // state register
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= ST_IDLE;
        end else begin
            r_state <= n_state;
        end
    end

    always_comb begin
        n_state = r_state;
        case (r_state)
            ST_IDLE: begin
                if (i_in_valid) n_state = ST_EXEC;
            end
            ST_EXEC: begin
                if (r_op == OP_DELAY && !w_oversize) begin
                    if (w_refill && !w_full) n_state = ST_MUL;
                    else n_state = ST_CHK;
                end else begin
                    n_state = ST_FIN;
                end
            end
            ST_MUL: begin
                if (r_cnt == MUL_LAST) n_state = ST_DIV;
            end
            ST_DIV: begin
                if (r_cnt == DIV_LAST) n_state = r_phase ? ST_ROUND : ST_ADD;
            end
            ST_ADD: n_state = ST_CHK;
            ST_CHK: begin
                if (r_level < w_wanted) n_state = ST_MUL;
                else n_state = ST_FIN;
            end
            ST_ROUND: n_state = ST_FIN;
            ST_FIN: begin
                if (w_out_free) n_state = ST_IDLE;
            end
            default: n_state = ST_IDLE;
        endcase
    end

    assign o_in_ready  = (r_state == ST_IDLE);
    assign o_cfg_ready = 1'b1;

    // block state, configuration and working registers
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_mem_lim <= MEM_LIMIT_RST;
            r_img_lim <= IMG_LIMIT_RST;
            r_rate    <= RATE_RST;
            r_mem_cnt <= '0;
            r_img_cnt <= '0;
            r_level   <= {RATE_RST, FRAC_W'(0)};
            r_last    <= '0;
            r_sticky  <= REASON_NONE;
            r_phase   <= 1'b0;
            r_cnt     <= '0;
        end else begin
            if (i_cfg_valid) begin
                case (i_cfg_index)
                    CFG_MEM_LIMIT: r_mem_lim <= i_cfg_data;
                    CFG_IMG_LIMIT: r_img_lim <= i_cfg_data;
                    CFG_RATE:      r_rate    <= i_cfg_data[RATE_W-1:0];
                    default: ;
                endcase
            end
            case (r_state)
                ST_IDLE: begin
                    if (i_in_valid) begin
                        r_op  <= i_op;
                        r_amt <= i_amount;
                        r_now <= i_now_ns;
                    end
                end
                ST_EXEC: begin
                    r_granted <= w_grant;
                    r_delay   <= '0;
                    case (r_op)
                        OP_RES_MEM: begin
                            if (w_mem_refuse) begin
                                if (r_sticky == REASON_NONE) r_sticky <= REASON_MEM;
                            end else begin
                                r_mem_cnt <= r_mem_cnt + r_amt;
                            end
                        end
                        OP_REL_MEM: begin
                            r_mem_cnt <= (r_amt >= r_mem_cnt) ? '0 : r_mem_cnt - r_amt;
                        end
                        OP_RES_IMG: begin
                            if (w_img_refuse) begin
                                if (r_sticky == REASON_NONE) r_sticky <= REASON_IMG;
                            end else begin
                                r_img_cnt <= r_img_cnt + r_amt;
                            end
                        end
                        OP_REC_IMG: begin
                            r_img_cnt <= r_amt;
                            if (r_amt > r_img_lim) begin
                                if (r_sticky == REASON_NONE) r_sticky <= REASON_IMG;
                            end
                        end
                        OP_DELAY: begin
                            if (w_oversize) begin
                                if (r_sticky == REASON_NONE) r_sticky <= REASON_OUT;
                            end else if (w_refill) begin
                                r_last <= r_now;
                                if (w_full) begin
                                    r_level <= w_cap;
                                end else begin
                                    r_acc   <= {(PROD_W-NS_W)'(0), w_diff[NS_W-1:0]};
                                    r_phase <= 1'b0;
                                    r_cnt   <= '0;
                                end
                            end
                        end
                        OP_CONSUME: begin
                            if (|r_amt[CNT_W-1:64-FRAC_W]) begin
                                r_level <= '0;
                            end else if (w_consume_w >= {2'b00, r_level}) begin
                                r_level <= '0;
                            end else begin
                                r_level <= r_level - w_consume_w[TOK_W-1:0];
                            end
                        end
                        default: ;
                    endcase
                end
                ST_MUL: begin
                    if (r_cnt == MUL_LAST) begin
                        // line up the dividend msb first: elapsed*rate*2^30 or missing*1e9
                        r_acc <= r_phase ? (w_mul_next << (PROD_W - DIV_W))
                                         : (w_mul_next << (PROD_W - TOK_W));
                        r_cnt <= '0;
                        r_rem <= '0;
                        r_quo <= '0;
                    end else begin
                        r_acc <= w_mul_next;
                        r_cnt <= r_cnt + STEP_W'(1);
                    end
                end
                ST_DIV: begin
                    r_rem <= w_rem_n[RATE_W-1:0];
                    r_quo <= {r_quo[TOK_W-2:0], w_ge};
                    r_acc <= {r_acc[PROD_W-2:0], 1'b0};
                    r_cnt <= (r_cnt == DIV_LAST) ? '0 : r_cnt + STEP_W'(1);
                end
                ST_ADD: begin
                    r_level <= (w_sum < {1'b0, w_cap}) ? w_sum[TOK_W-1:0] : w_cap;
                end
                ST_CHK: begin
                    if (r_level < w_wanted) begin
                        r_acc   <= {(PROD_W-TOK_W)'(0), w_wanted - r_level};
                        r_phase <= 1'b1;
                        r_cnt   <= '0;
                    end
                end
                ST_ROUND: begin
                    // ceil over rate, then ceil over the fraction scale
                    r_delay <= w_qc[FRAC_W+NS_W-1:FRAC_W]
                             + {{(NS_W-1){1'b0}}, (|w_qc[FRAC_W-1:0])};
                end
                default: ;
            endcase
        end
    end

    // result register
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (r_state == ST_FIN && w_out_free) begin
            r_out_valid <= 1'b1;
        end else if (i_out_ready) begin
            r_out_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (r_state == ST_FIN && w_out_free) begin
            r_o_granted <= r_granted;
            r_o_delay   <= r_delay;
            r_o_reason  <= r_sticky;
            r_o_mem     <= r_mem_cnt;
            r_o_img     <= r_img_cnt;
        end
    end

    assign o_out_valid     = r_out_valid;
    assign o_granted       = r_o_granted;
    assign o_delay_ns      = r_o_delay;
    assign o_first_hit     = r_o_reason;
    assign o_memory_in_use = r_o_mem;
    assign o_image_in_use  = r_o_img;

    a_sticky_holds: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_sticky != REASON_NONE) |=> (r_sticky == $past(r_sticky)))
        else $error("sticky reason changed after first limit hit");

    a_result_from_fin: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        $rose(r_out_valid) |-> $past(r_state == ST_FIN))
        else $error("result word raised outside the finish state");

    a_rem_bound: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == ST_DIV) |-> (r_rem < w_div_d))
        else $error("divider remainder not below divisor");

    a_accept_starts: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (i_in_valid && o_in_ready) |=> (r_state == ST_EXEC))
        else $error("accepted word did not start execution");

endmodule
